// File: sv/avs_pkg.sv
package avs_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_MIX   = 2'd3
  } avs_func_e;

  typedef enum logic [1:0] {
    CFG_CLIP_STEP  = 2'd0,
    CFG_TONE_PHASE = 2'd1,
    CFG_MUTE       = 2'd2,
    CFG_UNUSED     = 2'd3
  } avs_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_MUL,
    ST_SCALE,
    ST_MIX
  } avs_state_e;

  typedef struct packed {
    logic mul_en;
    logic scale_en;
  } avs_stage_t;

  // Integer part of the play position; also holds a 16-bit store address.
  localparam int unsigned POS_INT_W = 18;

  localparam logic [23:0] CLIP_STEP_RST  = 24'd14532;
  localparam logic [31:0] TONE_PHASE_RST = 32'd86390;

  localparam logic [15:0] TONE_HZ_LOW  = 16'd20;
  localparam logic [15:0] TONE_HZ_HIGH = 16'd20000;

  localparam logic signed [17:0] TONE_POS = 18'sd6000;
  localparam logic signed [17:0] TONE_NEG = -18'sd6000;
  localparam logic signed [17:0] SAT_MAX  = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN  = -18'sd32768;

  localparam logic signed [8:0] SILENCE = 9'sd128;

endpackage

// File: sv/avs_addr_mod.sv
module avs_addr_mod
  import avs_pkg::*;
#(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic [POS_INT_W-1:0]         val_i,
  output logic [$clog2(DEPTH)-1:0]     rem_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned VW = POS_INT_W;
  localparam int unsigned SH = VW + AW;
  localparam int unsigned MW = SH - 7;
  localparam int unsigned PW = VW + MW;
  localparam int unsigned DW = VW + AW + 1;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);

  logic [VW-1:0] val_q;
  logic [VW-1:0] quo_q;
  logic [PW-1:0] prod_w;
  logic [DW-1:0] back_w;
  logic [DW-1:0] diff_w;

  // The reciprocal is rounded up with enough bits that the quotient is exact.
  assign prod_w = PW'(val_i) * PW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q <= val_i;
      quo_q <= VW'(prod_w >> SH);
    end
  end

  assign back_w = DW'(quo_q) * DW'(DEPTH);
  assign diff_w = DW'(val_q) - back_w;
  assign rem_o  = diff_w[AW-1:0];

endmodule

// File: sv/avs_sample_store.sv
module avs_sample_store #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [7:0]               rdata_a_o,
  output logic [7:0]               rdata_b_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// File: sv/avs_clip_interp.sv
module avs_clip_interp
  import avs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  avs_stage_t           ctrl_i,
  input  logic [7:0]           smp_a_i,
  input  logic [7:0]           smp_b_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output logic signed [15:0]   part_o
);

  localparam int unsigned IW = FRAC_BITS + 10;
  localparam int unsigned NW = IW + 7;

  logic signed [8:0]           a_off_w;
  logic signed [8:0]           diff_w;
  logic signed [FRAC_BITS+9:0] slope_w;
  logic signed [IW-1:0]        base_w;
  logic signed [IW-1:0]        interp_d;
  logic signed [IW-1:0]        interp_q;
  logic signed [NW-1:0]        wide_w;
  logic signed [NW-1:0]        num_w;
  logic signed [NW-1:0]        bias_w;
  logic signed [NW-1:0]        biased_w;
  logic signed [NW-1:0]        shifted_w;
  logic signed [15:0]          part_q;

  // (a - 128) * one + (b - a) * frac equals the weighted sum less the offset.
  assign a_off_w  = $signed({1'b0, smp_a_i}) - SILENCE;
  assign diff_w   = $signed({1'b0, smp_b_i}) - $signed({1'b0, smp_a_i});
  assign slope_w  = diff_w * $signed({1'b0, frac_i});
  assign base_w   = IW'(a_off_w) <<< FRAC_BITS;
  assign interp_d = base_w + IW'(slope_w);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      interp_q <= interp_d;
    end
  end

  // Scale by 120 and drop the fraction, rounding toward zero.
  assign wide_w    = NW'(interp_q);
  assign num_w     = (wide_w <<< 7) - (wide_w <<< 3);
  assign bias_w    = num_w[NW-1] ? $signed({{(NW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                                 : '0;
  assign biased_w  = num_w + bias_w;
  assign shifted_w = biased_w >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scale_en) begin
      part_q <= shifted_w[15:0];
    end
  end

  assign part_o = part_q;

endmodule

// File: sv/audio_mixer_voc_speaker.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   func, store address and byte, clip length,
//                                                fm sample, tone enable, tone hz
// out       output     out_valid_o / out_stall_i audio_out, clip_active, clip_finished
// cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A mix frame goes from its transfer to its result through address reduction, sample
// store read, interpolation multiply, scaling and the final mix, which waits while a
// stalled result holds the output register. A byte write goes through address reduction
// and the store write; a clip start or stop is done at its transfer. One item is worked on at a time.
// Reset clears control state only; the sample store needs no clearing pass.
// A stalled result waits in the output register while the next item is taken.
module audio_mixer_voc_speaker
  import avs_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 65536,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [15:0]        store_address_i,
  input  logic [7:0]         store_byte_i,
  input  logic [16:0]        clip_length_i,
  input  logic signed [15:0] fm_sample_i,
  input  logic               tone_enable_i,
  input  logic [15:0]        tone_hz_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] audio_out_o,
  output logic               clip_active_o,
  output logic               clip_finished_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned POS_W = FRAC_BITS + POS_INT_W;

  avs_state_e state_q, state_d;
  avs_func_e  func_w;
  avs_func_e  func_q;
  avs_stage_t stage_w;

  logic [23:0] clip_step_q;
  logic [31:0] tone_rate_q;
  logic        muted_q;

  logic [POS_W-1:0]     pos_q;
  logic [16:0]          len_q;
  logic                 playing_q;
  logic [31:0]          phase_q;
  logic [POS_INT_W-1:0] pos_int_w;
  logic                 hit_w;
  logic                 in_xfer_w;
  logic                 out_xfer_w;
  logic                 load_out_w;

  logic [POS_INT_W-1:0] mod_val_w;
  logic [AW-1:0]        idx_a_w;
  logic [AW:0]          idx_inc_w;
  logic [AW-1:0]        idx_b_w;
  logic [7:0]           smp_a_w;
  logic [7:0]           smp_b_w;

  logic [7:0]           byte_q;
  logic signed [15:0]   fm_q;
  logic                 gate_q;
  logic [15:0]          hz_q;
  logic                 hit_q;
  logic                 act_q;
  logic                 fin_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [31:0]          tprod_q;
  logic signed [15:0]   part_w;

  logic signed [17:0] fm_ext_w;
  logic signed [17:0] clip_ext_w;
  logic signed [17:0] tone_ext_w;
  logic signed [17:0] sum_w;
  logic signed [15:0] mix_w;

  logic               out_valid_q;
  logic signed [15:0] audio_q;
  logic               out_act_q;
  logic               out_fin_q;

  assign func_w     = avs_func_e'(func_i);
  assign in_xfer_w  = in_valid_i && !in_stall_o;
  assign out_xfer_w = out_valid_q && !out_stall_i;
  assign pos_int_w  = pos_q[POS_W-1:FRAC_BITS];
  assign hit_w      = playing_q && ((19'(pos_int_w) + 19'd1) < 19'(len_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_step_q <= CLIP_STEP_RST;
      tone_rate_q <= TONE_PHASE_RST;
      muted_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (avs_cfg_e'(cfg_index_i))
        CFG_CLIP_STEP:  clip_step_q <= cfg_data_i[23:0];
        CFG_TONE_PHASE: tone_rate_q <= cfg_data_i;
        CFG_MUTE:       muted_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    load_out_w = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && (func_w == FUNC_WRITE || func_w == FUNC_MIX)) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_d = (func_q == FUNC_MIX) ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        state_d = ST_MIX;
      end
      ST_MIX: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out_w = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      playing_q <= 1'b0;
    end else if (in_xfer_w) begin
      unique case (func_w)
        FUNC_START: begin
          len_q     <= clip_length_i;
          pos_q     <= '0;
          playing_q <= (clip_length_i != '0);
        end
        FUNC_STOP: begin
          playing_q <= 1'b0;
        end
        FUNC_MIX: begin
          if (hit_w) begin
            pos_q <= pos_q + POS_W'(clip_step_q);
          end else begin
            playing_q <= 1'b0;
          end
        end
        FUNC_WRITE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (state_q == ST_MUL && gate_q) begin
      phase_q <= phase_q + tprod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer_w) begin
      func_q <= func_w;
      byte_q <= store_byte_i;
      fm_q   <= fm_sample_i;
      gate_q <= tone_enable_i && (tone_hz_i > TONE_HZ_LOW) && (tone_hz_i < TONE_HZ_HIGH);
      hz_q   <= tone_hz_i;
      hit_q  <= hit_w;
      act_q  <= hit_w;
      fin_q  <= playing_q && !hit_w;
      frac_q <= pos_q[FRAC_BITS-1:0];
    end
    if (state_q == ST_ADDR) begin
      tprod_q <= 32'(hz_q * tone_rate_q);
    end
  end

  assign mod_val_w = (func_w == FUNC_WRITE) ? POS_INT_W'(store_address_i) : pos_int_w;

  avs_addr_mod #(
    .DEPTH(STORE_DEPTH)
  ) u_addr_mod (
    .clk_i (clk_i),
    .load_i(in_xfer_w),
    .val_i (mod_val_w),
    .rem_o (idx_a_w)
  );

  assign idx_inc_w = (AW + 1)'(idx_a_w) + (AW + 1)'(1);
  assign idx_b_w   = (idx_inc_w == (AW + 1)'(STORE_DEPTH)) ? '0 : idx_inc_w[AW-1:0];

  avs_sample_store #(
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (state_q == ST_ADDR && func_q == FUNC_WRITE),
    .waddr_i  (idx_a_w),
    .wdata_i  (byte_q),
    .re_i     (state_q == ST_ADDR && func_q == FUNC_MIX),
    .raddr_a_i(idx_a_w),
    .raddr_b_i(idx_b_w),
    .rdata_a_o(smp_a_w),
    .rdata_b_o(smp_b_w)
  );

  assign stage_w.mul_en   = (state_q == ST_MUL);
  assign stage_w.scale_en = (state_q == ST_SCALE);

  avs_clip_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk_i  (clk_i),
    .ctrl_i (stage_w),
    .smp_a_i(smp_a_w),
    .smp_b_i(smp_b_w),
    .frac_i (frac_q),
    .part_o (part_w)
  );

  assign fm_ext_w   = 18'(fm_q);
  assign clip_ext_w = hit_q ? 18'(part_w) : 18'sd0;
  assign tone_ext_w = !gate_q ? 18'sd0 : (phase_q[31] ? TONE_NEG : TONE_POS);
  assign sum_w      = fm_ext_w + clip_ext_w + tone_ext_w;

  always_comb begin
    priority if (muted_q) begin
      mix_w = '0;
    end else if (sum_w > SAT_MAX) begin
      mix_w = SAT_MAX[15:0];
    end else if (sum_w < SAT_MIN) begin
      mix_w = SAT_MIN[15:0];
    end else begin
      mix_w = sum_w[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out_w) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer_w) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_w) begin
      audio_q   <= mix_w;
      out_act_q <= act_q;
      out_fin_q <= fin_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign audio_out_o     = audio_q;
  assign clip_active_o   = out_act_q;
  assign clip_finished_o = out_fin_q;

  a_result_from_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_MIX))
    else $error("result appeared outside the mix step");

  a_mul_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> $past(state_q == ST_ADDR) && func_q == FUNC_MIX)
    else $error("interpolation started without a store read");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out_w |-> !(act_q && fin_q))
    else $error("clip both active and finished on one frame");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pos_q[POS_W-1])
    else $error("play position exceeded its range");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |=> $stable(len_q))
    else $error("clip length changed while an item was in flight");

endmodule

// File: tb/sv/audio_mixer_voc_speaker_tb.sv
`timescale 1ns / 100ps

module audio_mixer_voc_speaker_tb;
  import avs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600_000;

  typedef struct {
    avs_func_e          func;
    logic [15:0]        addr;
    logic [7:0]         data;
    logic [16:0]        len;
    logic signed [15:0] fm;
    logic               tone_en;
    logic [15:0]        hz;
  } mix_item_t;

  typedef struct {
    logic signed [15:0] audio;
    logic               active;
    logic               finished;
  } frame_result_t;

  class mix_scoreboard;
    byte unsigned    store_mem [65536];
    bit              store_valid [65536];
    longint unsigned play_pos = 0;
    int unsigned     play_len = 0;
    bit              playing = 1'b0;
    logic [31:0]     phase = '0;
    logic [23:0]     step = CLIP_STEP_RST;
    logic [31:0]     phase_per_hz = TONE_PHASE_RST;
    bit              muted = 1'b0;
    frame_result_t   frames_due[$];
    int unsigned     n_err = 0;
    int unsigned     n_frames = 0;
    int unsigned     n_ends = 0;
    int unsigned     n_sat = 0;

    function void set_reg(avs_cfg_e idx, logic [31:0] val);
      case (idx)
        CFG_CLIP_STEP: begin
          step = val[23:0];
        end
        CFG_TONE_PHASE: begin
          phase_per_hz = val;
        end
        CFG_MUTE: begin
          muted = val[0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_input(mix_item_t it);
      longint          sum;
      longint          num;
      longint          part;
      longint unsigned p;
      longint unsigned frac;
      longint unsigned v;
      frame_result_t   r;
      case (it.func)
        FUNC_WRITE: begin
          store_mem[it.addr] = it.data;
          store_valid[it.addr] = 1'b1;
        end
        FUNC_START: begin
          play_len = it.len;
          play_pos = 0;
          playing = (it.len != 0);
        end
        FUNC_STOP: begin
          playing = 1'b0;
        end
        default: begin
          sum = it.fm;
          r.finished = 1'b0;
          if (playing) begin
            p = play_pos >> 16;
            if (p + 1 < play_len) begin
              frac = play_pos & 64'hFFFF;
              v = store_mem[p] * (64'd65536 - frac) + store_mem[p + 1] * frac;
              num = (longint'(v) - 8388608) * 120;
              part = (num < 0) ? -((-num) >>> 16) : (num >>> 16);
              sum += part;
              play_pos += step;
            end else begin
              playing = 1'b0;
              r.finished = 1'b1;
              n_ends++;
            end
          end
          if (it.tone_en && it.hz > 20 && it.hz < 20000) begin
            phase += it.hz * phase_per_hz;
            sum += (phase < 32'h8000_0000) ? 6000 : -6000;
          end
          if (sum > 32767) begin
            sum = 32767;
            n_sat++;
          end
          if (sum < -32768) begin
            sum = -32768;
            n_sat++;
          end
          if (muted) begin
            sum = 0;
          end
          r.audio = sum[15:0];
          r.active = playing;
          frames_due.push_back(r);
        end
      endcase
    endfunction

    function void report(string msg);
      n_err++;
      if (n_err <= 10) begin
        $display("MISMATCH %s", msg);
      end
    endfunction

    function void check_result(logic signed [15:0] audio, logic active, logic finished);
      frame_result_t e;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected frame: audio %0d active %0b finished %0b",
                         audio, active, finished));
        return;
      end
      e = frames_due.pop_front();
      n_frames++;
      if (audio !== e.audio || active !== e.active || finished !== e.finished) begin
        report($sformatf("frame %0d expected audio %0d active %0b finished %0b, got %0d %0b %0b",
                         n_frames, e.audio, e.active, e.finished, audio, active, finished));
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i = FUNC_WRITE;
  logic [15:0]        store_address_i = '0;
  logic [7:0]         store_byte_i = '0;
  logic [16:0]        clip_length_i = '0;
  logic signed [15:0] fm_sample_i = '0;
  logic               tone_enable_i = 1'b0;
  logic [15:0]        tone_hz_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] audio_out_o;
  logic               clip_active_o;
  logic               clip_finished_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = CFG_CLIP_STEP;
  logic [31:0]        cfg_data_i = '0;

  mix_scoreboard sb;
  int unsigned   cycle_count = 0;
  int unsigned   n_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   goal = 0;
  int unsigned   stall_mode = 0;
  int unsigned   stall_left = 0;

  audio_mixer_voc_speaker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .store_address_i (store_address_i),
    .store_byte_i    (store_byte_i),
    .clip_length_i   (clip_length_i),
    .fm_sample_i     (fm_sample_i),
    .tone_enable_i   (tone_enable_i),
    .tone_hz_i       (tone_hz_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .audio_out_o     (audio_out_o),
    .clip_active_o   (clip_active_o),
    .clip_finished_o (clip_finished_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("audio_mixer_voc_speaker_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(audio_out_o, clip_active_o, clip_finished_o);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= $urandom_range(0, 1);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  function automatic mix_item_t rand_item(avs_func_e f);
    mix_item_t it;
    it.func = f;
    it.addr = $urandom;
    it.data = $urandom;
    it.len = $urandom;
    it.fm = $urandom;
    it.tone_en = $urandom;
    it.hz = $urandom;
    return it;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return $urandom;
    endcase
  endfunction

  // The payload holds until the transfer; valid only drops when a burst ends.
  task automatic send_item(input mix_item_t it);
    in_valid_i <= 1'b1;
    func_i <= it.func;
    store_address_i <= it.addr;
    store_byte_i <= it.data;
    clip_length_i <= it.len;
    fm_sample_i <= it.fm;
    tone_enable_i <= it.tone_en;
    tone_hz_i <= it.hz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
    n_sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_write(input logic [15:0] a, input logic [7:0] d);
    mix_item_t it;
    it = rand_item(FUNC_WRITE);
    it.addr = a;
    it.data = d;
    send_item(it);
  endtask

  task automatic start_clip(input logic [16:0] len);
    mix_item_t it;
    it = rand_item(FUNC_START);
    it.len = len;
    send_item(it);
  endtask

  task automatic stop_clip();
    send_item(rand_item(FUNC_STOP));
  endtask

  // A frame may only read store bytes that were written, so missing ones are filled first.
  task automatic play_frame(input logic signed [15:0] fm, input logic en, input logic [15:0] hz);
    mix_item_t       it;
    longint unsigned p;
    p = sb.play_pos >> 16;
    if (sb.playing && p + 1 < sb.play_len) begin
      if (!sb.store_valid[p]) begin
        send_write(p[15:0], pick_byte());
      end
      if (!sb.store_valid[p + 1]) begin
        send_write(p[15:0] + 16'd1, pick_byte());
      end
    end
    it = rand_item(FUNC_MIX);
    it.fm = fm;
    it.tone_en = en;
    it.hz = hz;
    send_item(it);
  endtask

  task automatic random_frame();
    logic signed [15:0] fm;
    logic [15:0]        hz;
    case ($urandom_range(0, 7))
      0: fm = 16'sh7FFF;
      1: fm = 16'sh8000;
      2: fm = $urandom_range(0, 200) - 100;
      default: fm = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: hz = 16'd20;
      1: hz = 16'd21;
      2: hz = 16'd19999;
      3: hz = 16'd20000;
      4: hz = $urandom;
      default: hz = $urandom_range(21, 5000);
    endcase
    play_frame(fm, $urandom_range(0, 3) != 0, hz);
  endtask

  task automatic random_sequence();
    int unsigned n;
    case ($urandom_range(0, 9))
      0: begin
        send_write($urandom, pick_byte());
      end
      1: begin
        stop_clip();
        repeat ($urandom_range(1, 4)) random_frame();
      end
      2: begin
        case ($urandom_range(0, 4))
          0: start_clip(17'd0);
          1: start_clip(17'd1);
          2: start_clip(17'd2);
          3: start_clip(17'h10000);
          default: start_clip($urandom_range(0, 65536));
        endcase
        repeat ($urandom_range(1, 6)) random_frame();
      end
      default: begin
        start_clip(($urandom_range(0, 3) == 0) ? $urandom_range(50, 2000) : $urandom_range(2, 12));
        n = $urandom_range(4, 60);
        while (sb.playing && n != 0) begin
          random_frame();
          if ($urandom_range(0, 60) == 0) begin
            stop_clip();
          end
          n--;
        end
        random_frame();
      end
    endcase
  endtask

  task automatic cfg_write(input avs_cfg_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A byte write yields no frame, so the wait goes on past the last result to let any write finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    sb = new;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    send_write(16'hFFFF, 8'hA5);
    send_write(16'd0, 8'h00);
    send_write(16'd1, 8'hFF);
    send_write(16'd2, 8'h80);
    send_write(16'd3, 8'h7F);
    play_frame(16'sh7FFF, 1'b1, 16'd21);
    play_frame(16'sh8000, 1'b1, 16'd19999);
    play_frame(16'sd1234, 1'b1, 16'd20);
    play_frame(-16'sd1234, 1'b1, 16'd20000);
    play_frame(16'sd0, 1'b0, 16'd1000);
    play_frame(16'sd7, 1'b1, 16'hFFFF);
    start_clip(17'd0);
    play_frame(16'sd0, 1'b0, 16'd0);
    start_clip(17'd1);
    play_frame(16'sd0, 1'b0, 16'd0);
    start_clip(17'd4);
    play_frame(16'sd100, 1'b1, 16'd440);
    play_frame(-16'sd100, 1'b1, 16'd440);
    start_clip(17'd3);
    play_frame(16'sd0, 1'b0, 16'd0);
    stop_clip();
    play_frame(16'sd0, 1'b0, 16'd0);
    start_clip(17'h10000);
    play_frame(16'sd0, 1'b1, 16'd3000);
    play_frame(16'sd0, 1'b1, 16'd3000);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        1: begin
          cfg_write(CFG_CLIP_STEP, 32'h0001_0000);
          cfg_write(CFG_TONE_PHASE, 32'h0100_0000);
          cfg_write(CFG_MUTE, 32'd0);
        end
        2: begin
          cfg_write(CFG_CLIP_STEP, 32'd0);
          cfg_write(CFG_TONE_PHASE, 32'd0);
        end
        3: begin
          cfg_write(CFG_CLIP_STEP, 32'hFFFF_FFFF);
          cfg_write(CFG_TONE_PHASE, 32'hFFFF_FFFF);
        end
        4: begin
          cfg_write(CFG_MUTE, 32'd1);
          cfg_write(CFG_CLIP_STEP, $urandom_range(0, 32'h4_0000));
          cfg_write(CFG_TONE_PHASE, $urandom);
        end
        5: begin
          cfg_write(CFG_MUTE, 32'd0);
          cfg_write(CFG_CLIP_STEP, $urandom_range(4096, 32'h3_0000));
          cfg_write(CFG_TONE_PHASE, $urandom_range(0, 200000));
        end
        default: begin
        end
      endcase
      goal = n_sent + 180;
      while (n_sent < goal) random_sequence();
    end

    settle();
    repeat (12) @(posedge clk_i);
    $display("Sent %0d items; checked %0d mixed frames, %0d clip ends, %0d saturated sums.",
             n_sent, sb.n_frames, sb.n_ends, sb.n_sat);
    $display("Register settings: reset, unit step, zero step and tone, full scale, muted, random.");
    if (sb.n_err == 0) begin
      $display("audio_mixer_voc_speaker_tb: clean");
    end else begin
      $display("audio_mixer_voc_speaker_tb: errors");
    end
    $finish;
  end

endmodule
